// ===== hw/rtl/glyph_bitmap_row_blit_assert.svh =====
// Assertion macros for the glyph row blit checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef GLYPH_BITMAP_ROW_BLIT_ASSERT_SVH
`define GLYPH_BITMAP_ROW_BLIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBRB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GBRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/gbrb_pkg.sv =====
// Shared types, register indexes and colour expansion for the glyph row blit.
// No dependencies; used by glyph_bitmap_row_blit and gbrb_merge.
package gbrb_pkg;

    // Number of glyph columns carried by one input word, one lane each.
    localparam int LANES        = 32;
    localparam int GLYPH_HEIGHT = 32;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] CFG_BAND_TOP    = 3'd1;
    localparam logic [2:0] CFG_BAND_BOTTOM = 3'd2;
    localparam logic [2:0] CFG_WIDE_PIXELS = 3'd3;
    localparam logic [2:0] CFG_FILL_COLOUR = 3'd4;

    localparam logic [12:0] FRAME_WIDTH_RESET = 13'd320;

    // Reciprocal multipliers: x*255/31 == (x*255*RED_RECIP) >> 18 for 5-bit x,
    // and x*255/63 == (x*255*GREEN_RECIP) >> 20 for 6-bit x.
    localparam logic [31:0] RED_RECIP   = 32'd8457;
    localparam logic [31:0] GREEN_RECIP = 32'd16645;

    // Word handed from the row set-up stage to the write sequencer.
    typedef struct packed {
        logic               valid;
        logic [LANES-1:0]   mask;
        logic [23:0]        base;
        logic signed [15:0] left;
        logic [23:0]        value;
    } gbrb_load_t;

    // Expand RGB565 to 8:8:8: red (low five bits) lands in the top byte.
    function automatic logic [23:0] expand_colour(input logic [15:0] c);
        logic [31:0] r_prod;
        logic [31:0] g_prod;
        logic [31:0] b_prod;
        r_prod = (32'(c[4:0]) * 32'd255) * RED_RECIP;
        g_prod = (32'(c[10:5]) * 32'd255) * GREEN_RECIP;
        b_prod = (32'(c[15:11]) * 32'd255) * RED_RECIP;
        return {r_prod[25:18], g_prod[27:20], b_prod[25:18]};
    endfunction

endpackage

// ===== hw/rtl/glyph_bitmap_row_blit.sv =====
// Channel  | handshake             | word
// input    | in_valid / in_ready   | glyph_left, glyph_top, advance_width, glyph_row, row_bits
// output   | out_valid / out_ready | pixel_offset, pixel_value, last_in_row
// config   | cfg_write             | cfg_index, cfg_data
//
// A glyph row passes through capture and lane set-up, then its pixel writes go
// out in turn; the single output register limits writes to one per cycle while
// the output is not stalled. Reset is asynchronous, active low, and restores the
// register defaults. A stalled output holds its word; the next row is taken as
// soon as the previous row's last word sits in the output register.
// Depends on gbrb_pkg, gbrb_lane and gbrb_merge.
module glyph_bitmap_row_blit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] glyph_left,
    input  logic signed [15:0] glyph_top,
    input  logic [5:0]         advance_width,
    input  logic [4:0]         glyph_row,
    input  logic [31:0]        row_bits,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [23:0]        pixel_offset,
    output logic [23:0]        pixel_value,
    output logic               last_in_row
);
    import gbrb_pkg::*;

    logic [12:0]        frame_width_reg;
    logic [11:0]        band_top_reg;
    logic [12:0]        band_bottom_reg;
    logic               wide_pixels_reg;
    logic [15:0]        fill_colour_reg;

    logic               calc_reg;
    logic               calc_next;
    logic signed [15:0] left_reg;
    logic [5:0]         adv_reg;
    logic [31:0]        bits_reg;
    logic [15:0]        diff_reg;
    logic               row_ok_reg;

    logic signed [16:0] row;
    logic signed [16:0] diff;
    logic               row_ok;
    logic               accept;
    logic               merge_busy;
    logic [LANES-1:0]   hits;
    logic [28:0]        product;
    gbrb_load_t         load;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            band_top_reg    <= '0;
            band_bottom_reg <= '0;
            wide_pixels_reg <= 1'b0;
            fill_colour_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH: frame_width_reg <= cfg_data[12:0];
                CFG_BAND_TOP:    band_top_reg    <= cfg_data[11:0];
                CFG_BAND_BOTTOM: band_bottom_reg <= cfg_data[12:0];
                CFG_WIDE_PIXELS: wide_pixels_reg <= cfg_data[0];
                CFG_FILL_COLOUR: fill_colour_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Vertical clip on capture: screen row, its band offset and the band test.
    assign row    = 17'(glyph_top) + $signed({12'd0, glyph_row});
    assign diff   = row - $signed({5'd0, band_top_reg});
    assign row_ok = ({2'd0, glyph_row} < 7'(GLYPH_HEIGHT))
        && !diff[16]
        && (row < $signed({4'd0, band_bottom_reg}));

    assign in_ready = !calc_reg && !merge_busy;
    assign accept   = in_valid && in_ready;
    assign calc_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_reg <= 1'b0;
        end
        else
        begin
            calc_reg <= calc_next;
        end
    end

    // Captured input word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg   <= glyph_left;
            adv_reg    <= advance_width;
            bits_reg   <= row_bits;
            diff_reg   <= diff[15:0];
            row_ok_reg <= row_ok;
        end
    end

    // One lane per glyph column; byte 0 holds columns 0..7, MSB leftmost.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        gbrb_lane u_lane (
            .column        (5'(g)),
            .glyph_left    (left_reg),
            .advance_width (adv_reg),
            .frame_width   (frame_width_reg),
            .dot           (bits_reg[8 * (g / 8) + 7 - (g % 8)]),
            .hit           (hits[g])
        );
    end

    // Row base offset in the band buffer and the merged lane results.
    assign product    = 29'(diff_reg) * 29'(frame_width_reg);
    assign load.valid = calc_reg;
    assign load.mask  = row_ok_reg ? hits : '0;
    assign load.base  = product[23:0];
    assign load.left  = left_reg;
    assign load.value = wide_pixels_reg ? expand_colour(fill_colour_reg)
                                        : {8'd0, fill_colour_reg};

    gbrb_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .busy         (merge_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_offset (pixel_offset),
        .pixel_value  (pixel_value),
        .last_in_row  (last_in_row)
    );

endmodule

// ===== hw/rtl/gbrb_lane.sv =====
// One column lane: decides whether its glyph column produces a pixel write.
// Depends on nothing but its ports.
module gbrb_lane (
    input  logic [4:0]         column,
    input  logic signed [15:0] glyph_left,
    input  logic [5:0]         advance_width,
    input  logic [12:0]        frame_width,
    input  logic               dot,
    output logic               hit
);

    logic signed [16:0] screen_col;

    // Screen column of this lane, then the left, right and advance clips.
    assign screen_col = 17'(glyph_left) + $signed({12'd0, column});
    assign hit = dot
        && ({1'b0, column} < advance_width)
        && !screen_col[16]
        && (screen_col[15:0] < {3'd0, frame_width});

endmodule

// ===== hw/rtl/gbrb_merge.sv =====
// Write sequencer: walks the merged lane hits left to right, one word a cycle while the output is not stalled.
// Depends on gbrb_pkg for the load word type.
module gbrb_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  gbrb_pkg::gbrb_load_t load,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [23:0]         pixel_offset,
    output logic [23:0]         pixel_value,
    output logic                last_in_row
);
    import gbrb_pkg::*;

    logic [LANES-1:0]   mask_reg;
    logic [LANES-1:0]   mask_next;
    logic [23:0]        base_reg;
    logic signed [15:0] left_reg;
    logic [23:0]        value_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [23:0]        offset_reg;
    logic [23:0]        pvalue_reg;
    logic               last_reg;
    logic [4:0]         pick;
    logic [LANES-1:0]   rest;
    logic signed [16:0] col;
    logic               emit;

    // Lowest pending column goes out first.
    always_comb
    begin
        pick = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = 5'(i);
            end
        end
    end

    assign rest = mask_reg & (mask_reg - LANES'(1));
    assign col  = 17'(left_reg) + $signed({12'd0, pick});
    assign emit = (|mask_reg) && (!out_valid_reg || out_ready);

    // Next pending set and output slot occupancy.
    always_comb
    begin
        mask_next = mask_reg;
        if (load.valid)
        begin
            mask_next = load.mask;
        end
        else if (emit)
        begin
            mask_next = rest;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Row context and output word payload.
    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            base_reg  <= load.base;
            left_reg  <= load.left;
            value_reg <= load.value;
        end
        if (emit)
        begin
            offset_reg <= base_reg + 24'(col[12:0]);
            pvalue_reg <= value_reg;
            last_reg   <= (rest == '0);
        end
    end

    assign busy         = |mask_reg;
    assign out_valid    = out_valid_reg;
    assign pixel_offset = offset_reg;
    assign pixel_value  = pvalue_reg;
    assign last_in_row  = last_reg;

endmodule

// ===== hw/rtl/glyph_bitmap_row_blit_checker.sv =====
// Port-level checker for the glyph row blit, bound to the top level.
// Depends on glyph_bitmap_row_blit_assert.svh for the assertion macros.
`include "glyph_bitmap_row_blit_assert.svh"

module glyph_bitmap_row_blit_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] pixel_offset,
    input logic [23:0] pixel_value,
    input logic        last_in_row
);

    // A stalled output word holds.
    `GBRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_offset) && $stable(pixel_value) && $stable(last_in_row))

    // The set-up cycle after a row is taken never takes another row.
    `GBRB_ASSERT_NEXT(a_setup_gap, in_valid && in_ready, !in_ready)

    // No new row is taken while the current row still has writes to send.
    `GBRB_ASSERT_SAME(a_row_busy, out_valid && !last_in_row, !in_ready)

    // All writes of one row carry the same colour.
    `GBRB_ASSERT_NEXT(a_row_colour, out_valid && out_ready && !last_in_row, $stable(pixel_value))

endmodule

bind glyph_bitmap_row_blit glyph_bitmap_row_blit_checker u_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for glyph_bitmap_row_blit: directed rows from a table, then random rows.
// Depends on gbrb_pkg and the glyph_bitmap_row_blit RTL; needs no files or arguments.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gbrb_pkg::*;

    // Register index that maps to no register; writes to it must change nothing.
    localparam logic [2:0] CFG_SPARE = 3'd7;

    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 6;
    localparam int ROWS_PER_PHASE = 16;

    typedef struct packed {
        logic [12:0] fw;
        logic [11:0] bt;
        logic [12:0] bb;
        logic        wide;
        logic [15:0] fill;
    } cfg_set_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [5:0]         adv;
        logic [4:0]         grow;
        logic [31:0]        bits;
    } glyph_slice_t;

    typedef struct packed {
        logic [23:0] offset;
        logic [23:0] value;
        logic        last;
    } pixel_write_t;

    // One directed row: register setting, input word, and a typed expectation
    // (none or one write) where the answer is obvious; otherwise predicted.
    typedef struct packed {
        logic [2:0]   setting;
        glyph_slice_t slice;
        logic         typed;
        logic         typed_one;
        logic [23:0]  typed_offset;
        logic [23:0]  typed_value;
    } directed_row_t;

    // Setting 0 is the reset state and is never written.
    localparam cfg_set_t DIRECTED_SETTINGS [6] = '{
        '{13'd320,  12'd0,    13'd0,    1'b0, 16'h0000},
        '{13'd320,  12'd100,  13'd132,  1'b0, 16'hA5C3},
        '{13'd4096, 12'd0,    13'd4096, 1'b1, 16'hFFFF},
        '{13'd1,    12'd4095, 13'd4096, 1'b1, 16'h001F},
        '{13'd0,    12'd0,    13'd10,   1'b0, 16'h1234},
        '{13'd8191, 12'd0,    13'd8191, 1'b1, 16'hF800}
    };

    localparam directed_row_t DIRECTED_ROWS [24] = '{
        // Reset state: the band is empty, so nothing is written.
        '{3'd0, '{16'sd0, 16'sd0, 6'd8, 5'd0, 32'hFFFFFFFF}, 1'b1, 1'b0, 24'd0, 24'd0},
        // Single dots at the band corners.
        '{3'd1, '{16'sd0, 16'sd100, 6'd8, 5'd0, 32'h00000080}, 1'b1, 1'b1, 24'd0, 24'h00A5C3},
        '{3'd1, '{16'sd319, 16'sd100, 6'd1, 5'd31, 32'h00000080},
              1'b1, 1'b1, 24'd10239, 24'h00A5C3},
        // Row just past the band, row just above it, zero advance.
        '{3'd1, '{16'sd0, 16'sd101, 6'd8, 5'd31, 32'h000000FF}, 1'b1, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd0, 16'sd99, 6'd8, 5'd0, 32'h000000FF}, 1'b1, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd0, 16'sd100, 6'd0, 5'd0, 32'h000000FF}, 1'b1, 1'b0, 24'd0, 24'd0},
        // Origin extremes clip the whole row away; an empty row writes nothing.
        '{3'd1, '{16'sh8000, 16'sd100, 6'd32, 5'd0, 32'hFFFFFFFF}, 1'b1, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd32767, 16'sd100, 6'd32, 5'd0, 32'hFFFFFFFF}, 1'b1, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd0, 16'sd100, 6'd32, 5'd0, 32'h00000000}, 1'b1, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sh8000, 16'sh8000, 6'd8, 5'd31, 32'h000000FF}, 1'b1, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd0, 16'sd32767, 6'd8, 5'd0, 32'h000000FF}, 1'b1, 1'b0, 24'd0, 24'd0},
        // Left clip, right clip, a full row of 32 writes, advance past the row data.
        '{3'd1, '{-16'sd5, 16'sd100, 6'd32, 5'd2, 32'hFFFFFFFF}, 1'b0, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd300, 16'sd110, 6'd32, 5'd3, 32'hFFFFFFFF}, 1'b0, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd10, 16'sd100, 6'd32, 5'd5, 32'hFFFFFFFF}, 1'b0, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd0, 16'sd100, 6'd63, 5'd7, 32'hFFFFFFFF}, 1'b0, 1'b0, 24'd0, 24'd0},
        // Byte and bit order of the dots.
        '{3'd1, '{16'sd20, 16'sd100, 6'd32, 5'd8, 32'h00000001}, 1'b0, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd20, 16'sd100, 6'd32, 5'd8, 32'h01000000}, 1'b0, 1'b0, 24'd0, 24'd0},
        '{3'd1, '{16'sd40, 16'sd100, 6'd32, 5'd9, 32'hAAAA5555}, 1'b0, 1'b0, 24'd0, 24'd0},
        // Wide mode, white, and the largest offset.
        '{3'd2, '{16'sd0, 16'sd0, 6'd1, 5'd0, 32'h00000080}, 1'b1, 1'b1, 24'd0, 24'hFFFFFF},
        '{3'd2, '{16'sd4095, 16'sd4064, 6'd1, 5'd31, 32'h00000080},
              1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF},
        // One-pixel frame, top band row; pure red lands in the top byte.
        '{3'd3, '{16'sd0, 16'sd4095, 6'd32, 5'd0, 32'hFFFFFFFF}, 1'b1, 1'b1, 24'd0, 24'hFF0000},
        // Zero frame width writes nothing.
        '{3'd4, '{16'sd0, 16'sd0, 6'd8, 5'd0, 32'h000000FF}, 1'b1, 1'b0, 24'd0, 24'd0},
        // Offset wrap past 24 bits; pure blue lands in the low byte.
        '{3'd5, '{16'sd100, 16'sd5000, 6'd16, 5'd0, 32'h0000F0F0}, 1'b0, 1'b0, 24'd0, 24'd0},
        '{3'd5, '{16'sd0, 16'sd3, 6'd8, 5'd4, 32'h00000080}, 1'b1, 1'b1, 24'd57337, 24'h0000FF}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] glyph_left;
    logic signed [15:0] glyph_top;
    logic [5:0]         advance_width;
    logic [4:0]         glyph_row;
    logic [31:0]        row_bits;
    logic               out_valid;
    logic               out_ready;
    logic [23:0]        pixel_offset;
    logic [23:0]        pixel_value;
    logic               last_in_row;

    // Register values the block should hold right now.
    logic [12:0] fw_now;
    logic [11:0] bt_now;
    logic [12:0] bb_now;
    logic        wide_now;
    logic [15:0] fill_now;

    pixel_write_t pending_writes [$];
    pixel_write_t want_word;
    int           error_count;
    int           words_checked;
    int           rows_sent;
    int           settings_used;
    int           cycle_count;
    bit           calm;
    bit           backlog_hold;

    glyph_bitmap_row_blit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .glyph_left    (glyph_left),
        .glyph_top     (glyph_top),
        .advance_width (advance_width),
        .glyph_row     (glyph_row),
        .row_bits      (row_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_offset  (pixel_offset),
        .pixel_value   (pixel_value),
        .last_in_row   (last_in_row)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // RGB565 to 8:8:8 with red in the top byte and blue in the bottom byte.
    function automatic logic [23:0] widen_colour(input logic [15:0] c);
        int red;
        int green;
        int blue;
        red   = int'(c[4:0]) * 255 / 31;
        green = int'(c[10:5]) * 255 / 63;
        blue  = int'(c[15:11]) * 255 / 31;
        return {8'(red), 8'(green), 8'(blue)};
    endfunction

    // Queue the pixel writes that one glyph row should produce under the current registers.
    function automatic void predict_row_writes(input glyph_slice_t s);
        int          row_at;
        int          col_start;
        int          col_end;
        int          dot;
        int          first_slot;
        longint      row_base;
        logic [23:0] colour;
        if (int'(s.grow) >= GLYPH_HEIGHT)
            return;
        row_at = int'(s.top) + int'(s.grow);
        if (row_at < int'(bt_now) || row_at >= int'(bb_now))
            return;
        col_start = (int'(s.left) > 0) ? int'(s.left) : 0;
        col_end = int'(s.left) + int'(s.adv);
        if (col_end > int'(fw_now))
            col_end = int'(fw_now);
        if (col_start >= col_end)
            return;
        colour = wide_now ? widen_colour(fill_now) : {8'h00, fill_now};
        row_base = longint'(row_at - int'(bt_now)) * longint'(fw_now);
        first_slot = pending_writes.size();
        for (int col = col_start; col < col_end; col++)
        begin
            dot = col - int'(s.left);
            if (dot >= LANES)
                break;
            // Byte k holds dots 8k..8k+7 with the leftmost dot in its MSB.
            if (s.bits[8 * (dot / 8) + 7 - (dot % 8)])
                pending_writes.push_back('{24'(row_base + longint'(col)), colour, 1'b0});
        end
        if (pending_writes.size() > first_slot)
            pending_writes[$].last = 1'b1;
    endfunction

    function automatic cfg_set_t random_setting(input int unsigned k);
        cfg_set_t s;
        s.fw   = 13'($urandom_range(16, 640));
        s.bt   = 12'($urandom_range(0, 400));
        s.wide = k[0];
        s.fill = 16'($urandom);
        unique case (k)
            1: s.fw = 13'd4096;
            2: s.fw = 13'd1;
            3: s.bt = 12'd4095;
            default: ;
        endcase
        s.bb = (k == 3) ? 13'd4096 : 13'(int'(s.bt) + int'($urandom_range(8, 48)));
        return s;
    endfunction

    // Mostly rows that land in the band and near the frame; the rest is raw noise.
    function automatic glyph_slice_t random_row();
        glyph_slice_t s;
        int           row_at;
        s.bits = $urandom;
        s.grow = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 85)
        begin
            row_at = int'(bt_now);
            if (bb_now > 13'(bt_now))
                row_at += int'($urandom_range(0, int'(bb_now) - int'(bt_now) - 1));
            s.top  = 16'(row_at - int'(s.grow));
            s.left = 16'(int'($urandom_range(0, int'(fw_now) + 48)) - 24);
            s.adv  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                : 6'($urandom_range(0, 32));
        end
        else
        begin
            s.top  = 16'($urandom);
            s.left = 16'($urandom);
            s.adv  = 6'($urandom);
        end
        return s;
    endfunction

    // Offer one glyph row and hold it until accepted; queue its expected words on acceptance.
    task automatic offer_row(input glyph_slice_t s, input logic typed, input logic typed_one,
                             input logic [23:0] typed_offset, input logic [23:0] typed_value);
        in_valid      <= 1'b1;
        glyph_left    <= s.left;
        glyph_top     <= s.top;
        advance_width <= s.adv;
        glyph_row     <= s.grow;
        row_bits      <= s.bits;
        do
            @(posedge clk);
        while (!in_ready);
        if (!typed)
            predict_row_writes(s);
        else if (typed_one)
            pending_writes.push_back('{typed_offset, typed_value, 1'b1});
        rows_sent++;
        @(negedge clk);
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Let the block drain, wait out rows that write nothing, then program a new setting.
    task automatic settle_and_program(input cfg_set_t s);
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_FRAME_WIDTH, 16'(s.fw));
        write_reg(CFG_BAND_TOP, 16'(s.bt));
        write_reg(CFG_BAND_BOTTOM, 16'(s.bb));
        write_reg(CFG_WIDE_PIXELS, 16'(s.wide));
        write_reg(CFG_FILL_COLOUR, s.fill);
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_write <= 1'b0;
        fw_now   = s.fw;
        bt_now   = s.bt;
        bb_now   = s.bb;
        wide_now = s.wide;
        fill_now = s.fill;
        settings_used++;
        @(negedge clk);
    endtask

    // Receiver: one long hold-off on request, random stall bursts, none in the calm part.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (backlog_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                backlog_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare every accepted pixel word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                error_count++;
                $display("%0t: pixel word expected none, got offset=%h value=%h last=%b",
                         $realtime, pixel_offset, pixel_value, last_in_row);
            end
            else
            begin
                want_word = pending_writes.pop_front();
                words_checked++;
                if (pixel_offset !== want_word.offset)
                begin
                    error_count++;
                    $display("%0t: pixel_offset expected %h, got %h",
                             $realtime, want_word.offset, pixel_offset);
                end
                if (pixel_value !== want_word.value)
                begin
                    error_count++;
                    $display("%0t: pixel_value expected %h, got %h",
                             $realtime, want_word.value, pixel_value);
                end
                if (last_in_row !== want_word.last)
                begin
                    error_count++;
                    $display("%0t: last_in_row expected %b, got %b",
                             $realtime, want_word.last, last_in_row);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, random phases, then the final check.
    initial
    begin
        logic [2:0] current_setting;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_FRAME_WIDTH;
        cfg_data      = 16'h0000;
        in_valid      = 1'b0;
        glyph_left    = 16'sd0;
        glyph_top     = 16'sd0;
        advance_width = 6'd0;
        glyph_row     = 5'd0;
        row_bits      = 32'h0;
        fw_now        = FRAME_WIDTH_RESET;
        bt_now        = 12'd0;
        bb_now        = 13'd0;
        wide_now      = 1'b0;
        fill_now      = 16'h0000;
        error_count   = 0;
        words_checked = 0;
        rows_sent     = 0;
        settings_used = 1;
        cycle_count   = 0;
        calm          = 1'b0;
        backlog_hold  = 1'b0;
        current_setting = 3'd0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].setting != current_setting)
            begin
                current_setting = DIRECTED_ROWS[i].setting;
                settle_and_program(DIRECTED_SETTINGS[current_setting]);
            end
            maybe_idle();
            offer_row(DIRECTED_ROWS[i].slice, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_one,
                      DIRECTED_ROWS[i].typed_offset, DIRECTED_ROWS[i].typed_value);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle_and_program(random_setting(phase));
            if (phase == 0)
                backlog_hold = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                calm = 1'b1;
            for (int k = 0; k < ROWS_PER_PHASE; k++)
            begin
                maybe_idle();
                offer_row(random_row(), 1'b0, 1'b0, 24'd0, 24'd0);
            end
        end

        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d glyph rows under %0d register settings.",
                 rows_sent, settings_used);
        $display("%0d pixel words checked, %0d mismatches.", words_checked, error_count);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
